>>> design/lpfd_pkg.sv
`default_nettype none

package lpfd_pkg;

    // frame markers
    localparam logic [7:0] MARK_SHORT = 8'hC1;
    localparam logic [7:0] MARK_LONG  = 8'hC2;

    // smallest legal frame sizes for each marker form
    localparam logic [15:0] MIN_SHORT_SIZE = 16'd3;
    localparam logic [15:0] MIN_LONG_SIZE  = 16'd4;

    // reset value of the size limit register
    localparam logic [15:0] MAX_SIZE_RESET = 16'd4096;

    // error codes reported with each word
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MARKER = 2'd1;
    localparam logic [1:0] ERR_SIZE   = 2'd2;

    // register index of the size limit
    localparam logic REG_MAX_SIZE = 1'b0;

    // one result per received byte
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        in_frame;
        logic        frame_first;
        logic        frame_last;
        logic [7:0]  head_code;
        logic [15:0] frame_length;
        logic [1:0]  error_code;
    } lpfd_result_t;

endpackage

`default_nettype wire

>>> design/lpfd_parse.sv
`default_nettype none

module lpfd_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [15:0]           max_frame_size,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  datagram_last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output lpfd_pkg::lpfd_result_t     result
);
    import lpfd_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_SIZE,
        PH_SIZE_LOW,
        PH_HEAD,
        PH_BODY
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         long_form_reg, long_form_next;
    logic [7:0]   size_high_reg, size_high_next;
    logic [15:0]  declared_size_reg, declared_size_next;
    logic [15:0]  bytes_seen_reg, bytes_seen_next;
    logic [7:0]   held_head_reg, held_head_next;
    logic         discarding_reg, discarding_next;
    logic         valid_reg;
    lpfd_result_t result_reg, result_next;

    logic         accept;
    logic [15:0]  bytes_inc;
    logic [15:0]  size_short;
    logic [15:0]  size_long;
    logic [7:0]   head_sel;

    // result register frees up when empty or being drained
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    assign bytes_inc  = bytes_seen_reg + 16'd1;
    assign size_short = {8'd0, rx_byte};
    assign size_long  = {size_high_reg, rx_byte};
    assign head_sel   = (phase_reg == PH_HEAD) ? rx_byte : held_head_reg;

    // per-byte parse step
    always_comb
    begin
        phase_next         = phase_reg;
        long_form_next     = long_form_reg;
        size_high_next     = size_high_reg;
        declared_size_next = declared_size_reg;
        bytes_seen_next    = bytes_seen_reg;
        held_head_next     = held_head_reg;
        discarding_next    = discarding_reg;

        result_next              = '0;
        result_next.out_byte     = rx_byte;
        result_next.error_code   = ERR_NONE;

        if (discarding_reg)
        begin
            // drop until the datagram ends
            if (datagram_last)
                discarding_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_SIZE:
                begin
                    bytes_seen_next = bytes_inc;
                    if (long_form_reg)
                    begin
                        size_high_next       = rx_byte;
                        phase_next           = PH_SIZE_LOW;
                        result_next.in_frame = 1'b1;
                    end
                    else if (size_short >= MIN_SHORT_SIZE && size_short <= max_frame_size)
                    begin
                        declared_size_next   = size_short;
                        phase_next           = PH_HEAD;
                        result_next.in_frame = 1'b1;
                    end
                    else
                    begin
                        result_next.error_code = ERR_SIZE;
                        phase_next             = PH_WAIT;
                        discarding_next        = !datagram_last;
                    end
                end
                PH_SIZE_LOW:
                begin
                    bytes_seen_next = bytes_inc;
                    if (size_long >= MIN_LONG_SIZE && size_long <= max_frame_size)
                    begin
                        declared_size_next   = size_long;
                        phase_next           = PH_HEAD;
                        result_next.in_frame = 1'b1;
                    end
                    else
                    begin
                        result_next.error_code = ERR_SIZE;
                        phase_next             = PH_WAIT;
                        discarding_next        = !datagram_last;
                    end
                end
                PH_HEAD, PH_BODY:
                begin
                    held_head_next       = head_sel;
                    bytes_seen_next      = bytes_inc;
                    result_next.in_frame = 1'b1;
                    if (bytes_inc >= declared_size_reg)
                    begin
                        result_next.frame_last   = 1'b1;
                        result_next.head_code    = head_sel;
                        result_next.frame_length = declared_size_reg;
                        phase_next               = PH_WAIT;
                    end
                    else
                        phase_next = PH_BODY;
                end
                default:
                begin
                    // expecting a marker
                    if (rx_byte == MARK_SHORT || rx_byte == MARK_LONG)
                    begin
                        long_form_next          = (rx_byte == MARK_LONG);
                        bytes_seen_next         = 16'd1;
                        phase_next              = PH_SIZE;
                        result_next.in_frame    = 1'b1;
                        result_next.frame_first = 1'b1;
                    end
                    else
                    begin
                        result_next.error_code = ERR_MARKER;
                        phase_next             = PH_WAIT;
                        discarding_next        = !datagram_last;
                    end
                end
            endcase
        end
    end

    // parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT;
            long_form_reg     <= 1'b0;
            size_high_reg     <= '0;
            declared_size_reg <= '0;
            bytes_seen_reg    <= '0;
            held_head_reg     <= '0;
            discarding_reg    <= 1'b0;
            valid_reg         <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                long_form_reg     <= long_form_next;
                size_high_reg     <= size_high_next;
                declared_size_reg <= declared_size_next;
                bytes_seen_reg    <= bytes_seen_next;
                held_head_reg     <= held_head_next;
                discarding_reg    <= discarding_next;
                result_reg        <= result_next;
                valid_reg         <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> design/length_prefixed_frame_deframer.sv
// the result word is registered: it appears in the cycle after its input word is accepted
// throughput: one byte per cycle while m_tready takes each result, set by the single parse step
// feeding the result register; a new word is taken as the register drains in the same cycle
// reset: asynchronous, active low; parser waits for a marker, size limit returns to 4096
`default_nettype none

module length_prefixed_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // received byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // datagram_last
    // per-byte results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_byte, [15:8] head_code, [31:16] frame_length
    output logic [3:0]       m_tuser,   // [0] in_frame, [1] frame_first, [3:2] error_code
    output logic             m_tlast    // frame_last
);
    import lpfd_pkg::*;

    logic [15:0]  max_frame_size_reg;
    logic         cfg_write;
    lpfd_result_t result;

    // size limit register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_size_reg <= MAX_SIZE_RESET;
        else if (cfg_write)
            max_frame_size_reg <= pwdata[15:0];
    end

    assign prdata = (paddr[2] == REG_MAX_SIZE) ? {16'd0, max_frame_size_reg} : 32'd0;

    // parser with result register
    lpfd_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_frame_size (max_frame_size_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .rx_byte        (s_tdata),
        .datagram_last  (s_tlast),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result         (result)
    );

    // pack the result word
    assign m_tdata = {result.frame_length, result.head_code, result.out_byte};
    assign m_tuser = {result.error_code, result.frame_first, result.in_frame};
    assign m_tlast = result.frame_last;

    // a frame end or frame start is always part of an accepted frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tlast || m_tuser[1]) |-> m_tuser[0] && m_tuser[3:2] == ERR_NONE)
        else $error("frame boundary word outside a frame");

    // an error word never belongs to a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:2] != ERR_NONE |-> !m_tuser[0])
        else $error("error word marked in frame");

    // length and head code only appear on a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[31:8] == 24'd0)
        else $error("length or head code outside frame end");

    // a stalled result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire
